### hw/rtl/set_assoc_writeback_lru_cache_top_assert.svh
// Assertion macros shared by the checker.
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define SAWLC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sawlc check failed");

// Next-cycle implication.
`define SAWLC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sawlc check failed");

`endif

### hw/rtl/sawlc_pkg.sv
`timescale 1ns / 1ps

package sawlc_pkg;

	localparam int NUM_SETS_DEF      = 64;
	localparam int WAYS_PER_SET_DEF  = 4;
	localparam int LINE_BYTES_DEF    = 16;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	localparam logic [1:0] KIND_READ     = 2'd0;
	localparam logic [1:0] KIND_WRITE    = 2'd1;
	localparam logic [1:0] KIND_WB_WORD  = 2'd2;
	localparam logic [1:0] KIND_FILL_REQ = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] address;
		logic [31:0] data;
	} req_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_address;
		logic [31:0] out_data;
		logic        was_hit;
		logic        last_of_run;
	} rsp_t;

endpackage

### hw/rtl/sawlc_ram.sv
`timescale 1ns / 1ps

// Single-port synchronous RAM, registered read.
module sawlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/set_assoc_writeback_lru_cache_top.sv
`timescale 1ns / 1ps

// Set-associative write-back, write-allocate cache of 32-bit words with true LRU
// replacement. Requests (read, write, fill word) enter on req; results leave on rsp,
// each tagged with last_of_run on the final result of a request. Tags, valid/dirty
// bits, LRU ranks and the way count of a set sit in one metadata row of a
// single-port RAM; line words sit in a second single-port RAM. Both read through a
// register, so a write hit is done in LOOK, a read hit in LOOK then RDATA, a miss
// in LOOK, then WBRD and WBOUT for each writeback word, then FREQ for the fill
// request; each fill word is written from IDLE, the last one followed by FDONE.
// One request is in flight at a time. A per-set valid flop marks rows
// never written, which read as empty, so there is no clearing pass after reset.
// While a miss is pending, reads and writes are dropped; fill words and stray
// fills likewise when no miss is pending.
module set_assoc_writeback_lru_cache_top #(
	parameter int NUM_SETS     = sawlc_pkg::NUM_SETS_DEF,
	parameter int WAYS_PER_SET = sawlc_pkg::WAYS_PER_SET_DEF,
	parameter int LINE_BYTES   = sawlc_pkg::LINE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sawlc_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sawlc_pkg::rsp_t  rsp
);

	localparam int WORDS = LINE_BYTES / 4;
	localparam int OFFB  = $clog2(LINE_BYTES);
	localparam int IDXW  = $clog2(NUM_SETS);
	localparam int SETW  = (IDXW > 0) ? IDXW : 1;
	localparam int TAGW  = 32 - OFFB - IDXW;
	localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WAYW  = (WAYS_PER_SET > 1) ? $clog2(WAYS_PER_SET) : 1;
	localparam int CNTW  = $clog2(WAYS_PER_SET + 1);
	localparam int DADW  = SETW + WAYW + WIW;

	typedef struct packed {
		logic [CNTW-1:0]                    in_use;
		logic [WAYS_PER_SET-1:0][WAYW-1:0]  rank;
		logic [WAYS_PER_SET-1:0]            dirty;
		logic [WAYS_PER_SET-1:0]            valid;
		logic [WAYS_PER_SET-1:0][TAGW-1:0]  tag;
	} meta_t;

	localparam int MW = $bits(meta_t);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOOK  = 7'b0000010,
		ST_RDATA = 7'b0000100,
		ST_WBRD  = 7'b0001000,
		ST_WBOUT = 7'b0010000,
		ST_FREQ  = 7'b0100000,
		ST_FDONE = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic              pend_q;
	logic [1:0]        op_q;
	logic [31:0]       addr_q;
	logic [31:0]       data_q;
	logic [SETW-1:0]   set_q;
	logic [TAGW-1:0]   tag_q;
	logic [WIW-1:0]    wi_q;
	logic [WAYW-1:0]   way_q;
	logic [WIW-1:0]    fcnt_q;
	logic [WIW-1:0]    wbcnt_q;
	logic [31:0]       fill_word_q;
	logic [TAGW-1:0]   vtag_q;
	meta_t             row_q;
	logic [NUM_SETS-1:0] set_ok_q;
	logic              out_valid_q;
	sawlc_pkg::rsp_t   out_q;

	// RAM ports
	logic              meta_we, meta_re;
	logic [SETW-1:0]   meta_addr;
	meta_t             meta_wdata;
	logic [MW-1:0]     meta_rdata;
	logic              data_we, data_re;
	logic [DADW-1:0]   data_addr;
	logic [31:0]       data_wdata;
	logic [31:0]       data_rdata;

	// request decode
	logic [31:0]       req_line;
	logic [SETW-1:0]   req_set;
	logic [TAGW-1:0]   req_tag;
	logic [WIW-1:0]    req_wi;
	logic              accept;

	// lookup
	meta_t             meta;
	meta_t             upd;
	logic              hit;
	logic [WAYW-1:0]   hit_way;
	logic [WAYW-1:0]   vway;
	logic              fresh;
	logic [WAYW-1:0]   sel_way;
	logic [CNTW-1:0]   new_in_use;
	logic [WAYW-1:0]   old_rank;
	logic [WAYW-1:0]   best;

	logic              out_free;
	logic              emit;
	sawlc_pkg::rsp_t   emit_item;

	sawlc_ram #(.WIDTH(MW), .DEPTH(1 << SETW)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.re    (meta_re),
		.addr  (meta_addr),
		.wdata (meta_wdata),
		.rdata (meta_rdata)
	);

	sawlc_ram #(.WIDTH(32), .DEPTH(1 << DADW)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.re    (data_re),
		.addr  (data_addr),
		.wdata (data_wdata),
		.rdata (data_rdata)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	assign req_line = req.address >> OFFB;
	assign req_set  = SETW'(req_line & 32'(NUM_SETS - 1));
	assign req_tag  = TAGW'(req_line >> IDXW);
	assign req_wi   = WIW'((req.address >> 2) & 32'(WORDS - 1));

	// Tag compare, victim choice and LRU rank update on the row just read.
	always_comb begin
		meta     = set_ok_q[set_q] ? meta_t'(meta_rdata) : '0;
		hit      = 1'b0;
		hit_way  = '0;
		for (int w = 0; w < WAYS_PER_SET; w++) begin
			if (!hit && (w < int'(meta.in_use)) && meta.valid[w] && (meta.tag[w] == tag_q)) begin
				hit     = 1'b1;
				hit_way = WAYW'(w);
			end
		end
		best = meta.rank[0];
		if (int'(meta.in_use) < WAYS_PER_SET) begin
			vway  = WAYW'(meta.in_use);
			fresh = 1'b1;
		end else begin
			vway  = '0;
			fresh = 1'b0;
			for (int i = 1; i < WAYS_PER_SET; i++) begin
				if (meta.rank[i] > best) begin
					best = meta.rank[i];
					vway = WAYW'(i);
				end
			end
		end
		sel_way    = hit ? hit_way : vway;
		new_in_use = (!hit && fresh) ? CNTW'(meta.in_use + 1'b1) : meta.in_use;
		old_rank   = meta.rank[sel_way];
		upd        = meta;
		upd.in_use = new_in_use;
		for (int i = 0; i < WAYS_PER_SET; i++) begin
			if ((WAYW'(i) != sel_way) && (i < int'(new_in_use))
					&& ((!hit && fresh) || (meta.rank[i] < old_rank))) begin
				upd.rank[i] = WAYW'(meta.rank[i] + 1'b1);
			end
		end
		upd.rank[sel_way] = '0;
		if (hit) begin
			if (op_q == sawlc_pkg::OP_WRITE) begin
				upd.dirty[sel_way] = 1'b1;
			end
		end else begin
			upd.tag[sel_way]   = tag_q;
			upd.valid[sel_way] = 1'b0;
			upd.dirty[sel_way] = 1'b0;
		end
	end

	// Sequencer: RAM controls, result and next state.
	always_comb begin
		state_d    = state_q;
		meta_we    = 1'b0;
		meta_re    = 1'b0;
		meta_addr  = set_q;
		meta_wdata = upd;
		data_we    = 1'b0;
		data_re    = 1'b0;
		data_addr  = {set_q, way_q, wi_q};
		data_wdata = data_q;
		emit       = 1'b0;
		emit_item  = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.opcode == sawlc_pkg::OP_FILL) begin
						if (pend_q) begin
							data_we    = 1'b1;
							data_addr  = {set_q, way_q, fcnt_q};
							data_wdata = req.data;
							if (fcnt_q == WIW'(WORDS - 1)) begin
								state_d = ST_FDONE;
							end
						end
					end else if ((req.opcode == sawlc_pkg::OP_READ
							|| req.opcode == sawlc_pkg::OP_WRITE) && !pend_q) begin
						meta_re   = 1'b1;
						meta_addr = req_set;
						state_d   = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					meta_we   = 1'b1;
					data_addr = {set_q, sel_way, wi_q};
					if (hit) begin
						if (op_q == sawlc_pkg::OP_WRITE) begin
							data_we   = 1'b1;
							emit      = 1'b1;
							emit_item = '{out_kind: sawlc_pkg::KIND_WRITE, out_address: addr_q,
								out_data: '0, was_hit: 1'b1, last_of_run: 1'b1};
							state_d   = ST_IDLE;
						end else begin
							data_re = 1'b1;
							state_d = ST_RDATA;
						end
					end else if (meta.valid[vway] && meta.dirty[vway]) begin
						state_d = ST_WBRD;
					end else begin
						state_d = ST_FREQ;
					end
				end
			end
			ST_RDATA: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_item = '{out_kind: sawlc_pkg::KIND_READ, out_address: addr_q,
						out_data: data_rdata, was_hit: 1'b1, last_of_run: 1'b1};
					state_d   = ST_IDLE;
				end
			end
			ST_WBRD: begin
				data_re   = 1'b1;
				data_addr = {set_q, way_q, wbcnt_q};
				state_d   = ST_WBOUT;
			end
			ST_WBOUT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_item = '{out_kind: sawlc_pkg::KIND_WB_WORD,
						out_address: (32'(vtag_q) << (OFFB + IDXW)) | (32'(set_q) << OFFB)
							| (32'(wbcnt_q) << 2),
						out_data: data_rdata, was_hit: 1'b0, last_of_run: 1'b0};
					state_d   = (wbcnt_q == WIW'(WORDS - 1)) ? ST_FREQ : ST_WBRD;
				end
			end
			ST_FREQ: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_item = '{out_kind: sawlc_pkg::KIND_FILL_REQ,
						out_address: (addr_q >> OFFB) << OFFB,
						out_data: '0, was_hit: 1'b0, last_of_run: 1'b1};
					state_d   = ST_IDLE;
				end
			end
			ST_FDONE: begin
				if (out_free) begin
					// line becomes valid; a write miss lays its word over the fill
					meta_we                 = 1'b1;
					meta_wdata              = row_q;
					meta_wdata.valid[way_q] = 1'b1;
					meta_wdata.dirty[way_q] = (op_q == sawlc_pkg::OP_WRITE);
					emit                    = 1'b1;
					if (op_q == sawlc_pkg::OP_WRITE) begin
						data_we   = 1'b1;
						emit_item = '{out_kind: sawlc_pkg::KIND_WRITE, out_address: addr_q,
							out_data: '0, was_hit: 1'b0, last_of_run: 1'b1};
					end else begin
						emit_item = '{out_kind: sawlc_pkg::KIND_READ, out_address: addr_q,
							out_data: fill_word_q, was_hit: 1'b0, last_of_run: 1'b1};
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			fcnt_q      <= '0;
			wbcnt_q     <= '0;
			set_ok_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (meta_we) begin
				set_ok_q[set_q] <= 1'b1;
			end
			if (state_q == ST_IDLE && accept && req.opcode == sawlc_pkg::OP_FILL && pend_q) begin
				fcnt_q <= (fcnt_q == WIW'(WORDS - 1)) ? '0 : WIW'(fcnt_q + 1'b1);
			end
			if (state_q == ST_LOOK) begin
				wbcnt_q <= '0;
			end else if (state_q == ST_WBOUT && out_free) begin
				wbcnt_q <= WIW'(wbcnt_q + 1'b1);
			end
			if (state_q == ST_FREQ && out_free) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_FDONE && out_free) begin
				pend_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
		if (state_q == ST_IDLE && accept && req.opcode != sawlc_pkg::OP_FILL && !pend_q) begin
			op_q   <= req.opcode;
			addr_q <= req.address;
			data_q <= req.data;
			set_q  <= req_set;
			tag_q  <= req_tag;
			wi_q   <= req_wi;
		end
		if (state_q == ST_IDLE && accept && req.opcode == sawlc_pkg::OP_FILL && pend_q
				&& fcnt_q == wi_q) begin
			fill_word_q <= req.data;
		end
		if (state_q == ST_LOOK && out_free) begin
			way_q  <= sel_way;
			row_q  <= upd;
			vtag_q <= meta.tag[vway];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### hw/rtl/sawlc_checker.sv
`timescale 1ns / 1ps
`include "set_assoc_writeback_lru_cache_top_assert.svh"

module sawlc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input sawlc_pkg::rsp_t rsp
);

	logic is_fill_req;
	logic is_wb_word;
	logic is_access;

	assign is_fill_req = rsp_valid && (rsp.out_kind == sawlc_pkg::KIND_FILL_REQ);
	assign is_wb_word  = rsp_valid && (rsp.out_kind == sawlc_pkg::KIND_WB_WORD);
	assign is_access   = (rsp.out_kind == sawlc_pkg::KIND_READ)
		|| (rsp.out_kind == sawlc_pkg::KIND_WRITE);

	`SAWLC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`SAWLC_ASSERT_IMP(a_fill_req_last, is_fill_req, rsp.last_of_run && rsp.out_data == 32'd0)
	`SAWLC_ASSERT_IMP(a_wb_not_last, is_wb_word, !rsp.last_of_run && !rsp.was_hit)
	`SAWLC_ASSERT_IMP(a_hit_ends_run, rsp_valid && rsp.was_hit, rsp.last_of_run && is_access)

endmodule

bind set_assoc_writeback_lru_cache_top sawlc_checker u_sawlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### verif/tb_set_assoc_writeback_lru_cache_top.sv
`timescale 1ns / 1ps

// Cache model that works out the expected results, and the checker that
// compares them against what the block sends back.
class cache_scoreboard;
	localparam int SETS  = 64;
	localparam int WAYS  = 4;
	localparam int WORDS = 4;

	logic [21:0] tag_of [SETS*WAYS];
	bit          valid_of [SETS*WAYS];
	bit          dirty_of [SETS*WAYS];
	int unsigned rank_of [SETS*WAYS];
	int unsigned used_of [SETS];
	logic [31:0] word_of [SETS*WAYS*WORDS];

	bit          miss_open;
	logic [1:0]  miss_op;
	logic [31:0] miss_addr;
	logic [31:0] miss_data;
	int unsigned miss_set;
	int unsigned miss_way;
	int unsigned fill_count;

	sawlc_pkg::rsp_t expected_results[$];
	int mismatches;
	int checked;
	int hits;
	int misses;
	int evictions;

	function new();
		for (int i = 0; i < SETS*WAYS; i++) begin
			valid_of[i] = 0;
			dirty_of[i] = 0;
			rank_of[i]  = 0;
		end
		for (int i = 0; i < SETS; i++)
			used_of[i] = 0;
		miss_open = 0;
		fill_count = 0;
		mismatches = 0;
		checked = 0;
		hits = 0;
		misses = 0;
		evictions = 0;
	endfunction

	function void push_result(logic [1:0] kind, logic [31:0] a, logic [31:0] d,
			bit hit, bit last);
		sawlc_pkg::rsp_t r;
		r.out_kind    = kind;
		r.out_address = a;
		r.out_data    = d;
		r.was_hit     = hit;
		r.last_of_run = last;
		expected_results.push_back(r);
	endfunction

	// Make a way the most recent; fresh means it has just been taken into use.
	function void promote_way(int unsigned s, int unsigned w, bit fresh);
		int unsigned old;
		old = rank_of[s*WAYS + w];
		for (int unsigned i = 0; i < used_of[s] && i < WAYS; i++) begin
			if (i != w && (fresh || rank_of[s*WAYS + i] < old))
				rank_of[s*WAYS + i]++;
		end
		rank_of[s*WAYS + w] = 0;
	endfunction

	function void log_request(sawlc_pkg::req_t rq);
		int unsigned li, wi, s, w, base;
		logic [27:0] line;
		logic [21:0] tg;
		bit fresh;
		logic [31:0] vstart;
		if (rq.opcode == sawlc_pkg::OP_FILL) begin
			if (!miss_open)
				return;
			li = miss_set*WAYS + miss_way;
			word_of[li*WORDS + fill_count] = rq.data;
			fill_count++;
			if (fill_count < WORDS)
				return;
			fill_count = 0;
			miss_open = 0;
			valid_of[li] = 1;
			wi = 32'(miss_addr[3:2]);
			if (miss_op == sawlc_pkg::OP_WRITE) begin
				word_of[li*WORDS + wi] = miss_data;
				dirty_of[li] = 1;
				push_result(sawlc_pkg::KIND_WRITE, miss_addr, '0, 0, 1);
			end else begin
				dirty_of[li] = 0;
				push_result(sawlc_pkg::KIND_READ, miss_addr, word_of[li*WORDS + wi], 0, 1);
			end
			return;
		end
		if (rq.opcode == 2'd3 || miss_open)
			return;
		line = rq.address[31:4];
		s    = 32'(line[5:0]);
		tg   = line[27:6];
		wi   = 32'(rq.address[3:2]);
		base = s*WAYS;
		for (int unsigned k = 0; k < used_of[s] && k < WAYS; k++) begin
			if (valid_of[base+k] && tag_of[base+k] == tg) begin
				promote_way(s, k, 0);
				hits++;
				if (rq.opcode == sawlc_pkg::OP_WRITE) begin
					word_of[(base+k)*WORDS + wi] = rq.data;
					dirty_of[base+k] = 1;
					push_result(sawlc_pkg::KIND_WRITE, rq.address, '0, 1, 1);
				end else begin
					push_result(sawlc_pkg::KIND_READ, rq.address,
						word_of[(base+k)*WORDS + wi], 1, 1);
				end
				return;
			end
		end
		misses++;
		if (used_of[s] < WAYS) begin
			w = used_of[s];
			used_of[s]++;
			fresh = 1;
		end else begin
			w = 0;
			for (int unsigned k = 1; k < WAYS; k++)
				if (rank_of[base+k] > rank_of[base+w])
					w = k;
			fresh = 0;
		end
		if (valid_of[base+w] && dirty_of[base+w]) begin
			evictions++;
			vstart = {tag_of[base+w], s[5:0], 4'h0};
			for (int unsigned k = 0; k < WORDS; k++)
				push_result(sawlc_pkg::KIND_WB_WORD, vstart + 4*k,
					word_of[(base+w)*WORDS + k], 0, 0);
		end
		promote_way(s, w, fresh);
		tag_of[base+w]   = tg;
		valid_of[base+w] = 0;
		dirty_of[base+w] = 0;
		push_result(sawlc_pkg::KIND_FILL_REQ, {line, 4'h0}, '0, 0, 1);
		miss_open  = 1;
		miss_op    = rq.opcode;
		miss_addr  = rq.address;
		miss_data  = rq.data;
		miss_set   = s;
		miss_way   = w;
		fill_count = 0;
	endfunction

	function void check_result(sawlc_pkg::rsp_t got);
		sawlc_pkg::rsp_t want;
		checked++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result %p", $realtime, got);
			return;
		end
		want = expected_results.pop_front();
		if (got.out_kind != want.out_kind || got.out_address != want.out_address ||
				got.out_data != want.out_data || got.was_hit != want.was_hit ||
				got.last_of_run != want.last_of_run) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch expected %p actual %p", $realtime, want, got);
		end
	endfunction
endclass

module tb_set_assoc_writeback_lru_cache_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 10000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	sawlc_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	sawlc_pkg::rsp_t rsp;

	cache_scoreboard sb;
	bit quiet;        // final stretch: no idling on either side
	bit hold_request; // ask the receiver for one long hold-off
	int sent;
	int idle_cycles;
	logic [21:0] tag_pool [8];

	set_assoc_writeback_lru_cache_top uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Result side: every accepted transfer goes to the checker.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off to back the block up.
	initial begin
		rsp_stall <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				rsp_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				rsp_stall <= 0;
			end
		end
	end

	// One request transfer, with an occasional idle burst in front of it.
	task automatic send(input logic [1:0] op, input logic [31:0] a, input logic [31:0] d);
		sawlc_pkg::req_t rq;
		rq.opcode  = op;
		rq.address = a;
		rq.data    = d;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1;
		req <= rq;
		do @(posedge clk); while (req_stall);
		sb.log_request(rq);
		sent++;
	endtask

	// An access, followed by the line fill if it missed.
	task automatic access(input logic [1:0] op, input logic [31:0] a, input logic [31:0] d);
		send(op, a, d);
		while (sb.miss_open)
			send(sawlc_pkg::OP_FILL, $urandom, $urandom);
	endtask

	function automatic logic [31:0] pick_address();
		logic [5:0] s;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		case ($urandom_range(0, 4))
			0: s = 6'd0;
			1: s = 6'd63;
			default: s = 6'($urandom_range(1, 3));
		endcase
		return {tag_pool[$urandom_range(0, 7)], s, 4'($urandom)};
	endfunction

	initial begin
		sb = new();
		quiet = 0;
		hold_request = 0;
		sent = 0;
		idle_cycles = 0;
		arst_n = 0;
		req_valid <= 0;
		req <= '0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = 22'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: unused opcode, stray fill, read miss then hits
		send(OP_UNUSED, 32'h0, 32'h0);
		send(sawlc_pkg::OP_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		access(sawlc_pkg::OP_READ, 32'h0, 32'h0);
		access(sawlc_pkg::OP_WRITE, 32'h4, 32'hFFFF_FFFF);
		access(sawlc_pkg::OP_READ, 32'h7, 32'h0);
		// access while a miss is pending is dropped
		send(sawlc_pkg::OP_WRITE, 32'hFFFF_FFFC, 32'hA5A5_A5A5);
		send(sawlc_pkg::OP_READ, 32'h0, 32'h0);
		send(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		while (sb.miss_open)
			send(sawlc_pkg::OP_FILL, 32'h0, $urandom);
		// fill set 0 with dirty lines until the oldest is written back
		for (int t = 1; t < 5; t++)
			access(sawlc_pkg::OP_WRITE, {22'(t), 6'd0, 4'h8}, $urandom);

		// random sequences: mostly well-formed, with some dropped traffic mixed in
		while (sent < 470) begin
			if (sent >= 250 && sent < 260 && !hold_request)
				hold_request = 1;
			if (sent >= 410)
				quiet = 1;
			case ($urandom_range(0, 19))
				0: send(OP_UNUSED, $urandom, $urandom);
				1: send(sawlc_pkg::OP_FILL, $urandom, $urandom);
				default: begin
					send($urandom_range(0, 1) ? sawlc_pkg::OP_WRITE : sawlc_pkg::OP_READ,
						pick_address(), $urandom);
					while (sb.miss_open) begin
						if ($urandom_range(0, 9) == 0)
							send(2'($urandom_range(0, 1)) | ($urandom_range(0, 1) ? 2'd0 : OP_UNUSED),
								$urandom, $urandom);
						else
							send(sawlc_pkg::OP_FILL, $urandom, $urandom);
					end
				end
			endcase
		end
		req_valid <= 0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d requests: %0d hits, %0d misses, %0d dirty evictions.",
			sent, sb.hits, sb.misses, sb.evictions);
		$display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
